@@ hdl/assert_macros.svh @@
// Assertion helpers shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge while reset is inactive.
`define RIP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define RIP_ASSERT_IMPL(label, cond, cons, msg) \
	`RIP_ASSERT(label, (cond) |-> (cons), msg)

// Check that a condition implies a consequence in the following cycle.
`define RIP_ASSERT_NEXT(label, cond, cons, msg) \
	`RIP_ASSERT(label, (cond) |=> (cons), msg)

`endif

@@ hdl/rip_pkg.sv @@
package rip_pkg;

	// Configuration register indexes
	localparam logic [2:0] REG_RADIX       = 3'd0;
	localparam logic [2:0] REG_SIGNED_MODE = 3'd1;
	localparam logic [2:0] REG_VALUE_WIDTH = 3'd2;
	localparam logic [2:0] REG_ALLOW_PLUS  = 3'd3;
	localparam logic [2:0] REG_ALLOW_LZ    = 3'd4;
	localparam logic [2:0] REG_UPPER_CASE  = 3'd5;

	// Result width codes
	localparam logic [1:0] VW_8  = 2'd0;
	localparam logic [1:0] VW_16 = 2'd1;
	localparam logic [1:0] VW_32 = 2'd2;
	localparam logic [1:0] VW_64 = 2'd3;

	localparam logic [5:0] RADIX_RESET = 6'd10;

	typedef struct packed {
		logic [5:0] radix;
		logic       signed_mode;
		logic [1:0] value_width;
		logic       allow_plus;
		logic       allow_leading_zero;
		logic       upper_case;
	} cfg_t;

	// Controller to datapath
	typedef struct packed {
		logic capture;
		logic commit;
		logic load_out;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic last_s1;
	} status_t;

endpackage

@@ hdl/rip_cfg.sv @@
module rip_cfg (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [2:0]      cfg_index,
	input  logic [5:0]      cfg_data,
	output rip_pkg::cfg_t   cfg
);
	import rip_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg      = cfg_q;

	// Write the addressed register; drop writes past the list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.radix              <= RADIX_RESET;
			cfg_q.signed_mode        <= 1'b0;
			cfg_q.value_width        <= VW_64;
			cfg_q.allow_plus         <= 1'b0;
			cfg_q.allow_leading_zero <= 1'b0;
			cfg_q.upper_case         <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_RADIX:       cfg_q.radix              <= cfg_data;
				REG_SIGNED_MODE: cfg_q.signed_mode        <= cfg_data[0];
				REG_VALUE_WIDTH: cfg_q.value_width        <= cfg_data[1:0];
				REG_ALLOW_PLUS:  cfg_q.allow_plus         <= cfg_data[0];
				REG_ALLOW_LZ:    cfg_q.allow_leading_zero <= cfg_data[0];
				REG_UPPER_CASE:  cfg_q.upper_case         <= cfg_data[0];
				default: ;
			endcase
		end
	end

endmodule

@@ hdl/rip_dp.sv @@
module rip_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  rip_pkg::cfg_t     cfg,
	input  rip_pkg::cmd_t     cmd,
	output rip_pkg::status_t  status,
	input  logic [15:0]       code_unit,
	input  logic              last_unit,
	output logic              accepted,
	output logic [63:0]       value
);
	import rip_pkg::*;

	localparam logic [1:0]  PH_START = 2'd0;
	localparam logic [1:0]  PH_SIGN  = 2'd1;
	localparam logic [1:0]  PH_DIGIT = 2'd2;
	localparam logic [15:0] CH_PLUS  = 16'h002B;
	localparam logic [15:0] CH_MINUS = 16'h002D;
	localparam logic [15:0] CH_ZERO  = 16'h0030;
	localparam logic [15:0] CH_NINE  = 16'h0039;
	localparam logic [15:0] CH_UPPER = 16'h0041;
	localparam logic [15:0] CH_LOWER = 16'h0061;

	// String state
	logic [63:0] acc_q;
	logic [1:0]  phase_q;
	logic        neg_q, rej_q, fwz_q;

	// Captured item and product
	logic [15:0] unit_s1;
	logic        last_s1;
	logic [69:0] prod_s1;

	logic        accepted_q;
	logic [63:0] value_q;

	// Next-state values
	logic [63:0] acc_n;
	logic [1:0]  phase_n;
	logic        neg_n, rej_n, fwz_n, take, fin_rej;

	logic [15:0] letter_base, letter_off;
	logic        is_num, is_let, is_dig, bad;
	logic [5:0]  dig;
	logic [63:0] umask, half, lim, signed_v, masked_v, out_v;
	logic [69:0] sum;
	logic        ovf;

	assign status.last_s1 = last_s1;
	assign accepted       = accepted_q;
	assign value          = value_q;

	// Capture the unit and the accumulator times the radix
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			unit_s1 <= code_unit;
			last_s1 <= last_unit;
			prod_s1 <= 70'(acc_q) * 70'(cfg.radix);
		end
	end

	// Decode the digit
	always_comb begin
		letter_base = cfg.upper_case ? CH_UPPER : CH_LOWER;
		letter_off  = unit_s1 - letter_base;
		is_num      = (unit_s1 >= CH_ZERO) && (unit_s1 <= CH_NINE);
		is_let      = (unit_s1 >= letter_base) && (letter_off <= 16'd25);
		is_dig      = is_num || is_let;
		if (is_num) dig = 6'(unit_s1 - CH_ZERO);
		else        dig = 6'(letter_off) + 6'd10;
		bad = !is_dig || (cfg.radix == 6'd0) || (dig >= cfg.radix);
	end

	// Width masks and magnitude limit
	always_comb begin
		unique case (cfg.value_width)
			VW_8:    begin umask = 64'h0000_0000_0000_00FF; half = 64'h0000_0000_0000_0080; end
			VW_16:   begin umask = 64'h0000_0000_0000_FFFF; half = 64'h0000_0000_0000_8000; end
			VW_32:   begin umask = 64'h0000_0000_FFFF_FFFF; half = 64'h0000_0000_8000_0000; end
			default: begin umask = 64'hFFFF_FFFF_FFFF_FFFF; half = 64'h8000_0000_0000_0000; end
		endcase
		if (cfg.signed_mode) lim = neg_q ? half : half - 64'd1;
		else                 lim = umask;
		sum = prod_s1 + 70'(dig);
		ovf = sum > 70'(lim);
	end

	// Advance the parse by one unit
	always_comb begin
		acc_n   = acc_q;
		phase_n = phase_q;
		neg_n   = neg_q;
		rej_n   = rej_q;
		fwz_n   = fwz_q;
		take    = 1'b0;
		if (!rej_q) begin
			unique case (phase_q)
				PH_START: begin
					if (unit_s1 == CH_PLUS) begin
						if (cfg.allow_plus) phase_n = PH_SIGN;
						else                rej_n   = 1'b1;
					end else if (unit_s1 == CH_MINUS && cfg.signed_mode) begin
						neg_n   = 1'b1;
						phase_n = PH_SIGN;
					end else begin
						take = 1'b1;
					end
				end
				PH_SIGN: take = 1'b1;
				default: begin
					if (fwz_q && !cfg.allow_leading_zero) rej_n = 1'b1;
					else                                  take  = 1'b1;
				end
			endcase
		end
		if (take) begin
			if (bad || ovf) begin
				rej_n = 1'b1;
			end else begin
				acc_n = sum[63:0];
				if (phase_q != PH_DIGIT) begin
					fwz_n   = (unit_s1 == CH_ZERO);
					phase_n = PH_DIGIT;
				end
			end
		end
		fin_rej = rej_n || (phase_n != PH_DIGIT);
	end

	// Negate, mask and extend the result
	always_comb begin
		signed_v = neg_n ? (64'd0 - acc_n) : acc_n;
		masked_v = signed_v & umask;
		if (cfg.signed_mode && (cfg.value_width != VW_64) && ((masked_v & half) != 64'd0))
			out_v = masked_v | ~umask;
		else
			out_v = masked_v;
	end

	// Commit string state; clear it after the last unit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= 64'd0;
			phase_q <= PH_START;
			neg_q   <= 1'b0;
			rej_q   <= 1'b0;
			fwz_q   <= 1'b0;
		end else if (cmd.commit) begin
			if (last_s1) begin
				acc_q   <= 64'd0;
				phase_q <= PH_START;
				neg_q   <= 1'b0;
				rej_q   <= 1'b0;
				fwz_q   <= 1'b0;
			end else begin
				acc_q   <= acc_n;
				phase_q <= phase_n;
				neg_q   <= neg_n;
				rej_q   <= rej_n;
				fwz_q   <= fwz_n;
			end
		end
	end

	// Load the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accepted_q <= 1'b0;
			value_q    <= 64'd0;
		end else if (cmd.load_out) begin
			accepted_q <= !fin_rej;
			value_q    <= fin_rej ? 64'd0 : out_v;
		end
	end

	`include "assert_macros.svh"

	`RIP_ASSERT_IMPL(a_reject_zero, !accepted_q, value_q == 64'd0, "rejected result carries a value")
	`RIP_ASSERT_NEXT(a_clear_after_last, cmd.commit && last_s1, phase_q == PH_START && !rej_q, "state not cleared after last unit")

endmodule

@@ hdl/rip_ctrl.sv @@
module rip_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  rip_pkg::status_t  status,
	output rip_pkg::cmd_t     cmd
);
	import rip_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

	state_t state_q, state_n;
	logic   out_valid_q, out_free;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;

	// Sequence capture and execute; a last unit waits for a free result register
	always_comb begin
		state_n      = state_q;
		cmd.capture  = 1'b0;
		cmd.commit   = 1'b0;
		cmd.load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_n     = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (!status.last_s1 || out_free) begin
					cmd.commit   = 1'b1;
					cmd.load_out = status.last_s1;
					state_n      = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// Hold the result beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	`include "assert_macros.svh"

	`RIP_ASSERT_NEXT(a_capture_exec, cmd.capture, state_q == ST_EXEC, "capture did not enter execute")
	`RIP_ASSERT_IMPL(a_load_on_last, cmd.load_out, cmd.commit && status.last_s1, "result load without last unit")
	`RIP_ASSERT_NEXT(a_wait_full, state_q == ST_EXEC && status.last_s1 && out_valid_q && out_stall, state_q == ST_EXEC && out_valid_q, "last unit overran a waiting result")

endmodule

@@ hdl/radix_integer_parser.sv @@
// Parses a UTF-16 string, one code unit per input beat, into an 8/16/32/64-bit
// integer in the configured radix, and gives one result beat (accepted, value) on
// the unit marked last. For each code unit, the accept cycle registers the unit
// and the accumulator times the radix, and the execute state then adds the
// digit, checks the width limit and updates the string state. A last unit holds
// in the execute state while the previous result still waits on a stalled output.
// Configuration writes complete in the cycle they are presented and should be
// made only while no string is in progress.
module radix_integer_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] code_unit,
	input  logic        last_unit,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        accepted,
	output logic [63:0] value,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [5:0]  cfg_data
);
	import rip_pkg::*;

	cfg_t    cfg;
	cmd_t    cmd;
	status_t status;

	rip_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	rip_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	rip_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd       (cmd),
		.status    (status),
		.code_unit (code_unit),
		.last_unit (last_unit),
		.accepted  (accepted),
		.value     (value)
	);

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 100ps

module tb;
	import rip_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_CYCLES = 20;
	localparam int LONG_HOLD = 300;
	localparam int PHASE_UNITS = 45;

	// Character codes seen by the parser
	localparam logic [15:0] CH_ZERO = 16'h0030;
	localparam logic [15:0] CH_NINE = 16'h0039;
	localparam logic [15:0] CH_PLUS = 16'h002B;
	localparam logic [15:0] CH_MINUS = 16'h002D;
	localparam logic [15:0] CH_UPPER_A = 16'h0041;
	localparam logic [15:0] CH_LOWER_A = 16'h0061;
	localparam int LETTER_SPAN = 26;

	// First index that maps to no register
	localparam logic [2:0] NO_REG_FIRST = 3'd6;

	typedef enum logic [1:0] {AT_START, AFTER_SIGN, IN_DIGITS} parse_phase_t;

	typedef struct {
		logic [15:0] code;
		logic        fin;
	} text_unit_t;

	typedef struct {
		logic        ok;
		logic [63:0] val;
	} parse_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [15:0] code_unit = '0;
	logic        last_unit = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        accepted;
	logic [63:0] value;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [5:0]  cfg_data = '0;

	radix_integer_parser uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.code_unit(code_unit),
		.last_unit(last_unit),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.accepted(accepted),
		.value(value),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Parser shadow: configuration and the state of the string in progress
	cfg_t         cfg;
	logic [63:0]  str_mag = '0;
	parse_phase_t str_phase = AT_START;
	bit           str_neg = 1'b0;
	bit           str_bad = 1'b0;
	bit           str_lead_zero = 1'b0;

	text_unit_t    text_q[$];
	parse_result_t pending_results[$];
	logic [15:0]   draft[$];
	text_unit_t    beat;
	parse_result_t want;
	logic          exp_ok;
	logic [63:0]   exp_val;

	int units_offered = 0;
	int units_taken = 0;
	int send_mode = 0;
	int stall_mode = 0;
	int burst_left = 0;
	int gap_left = 0;
	int hold_requests = 0;
	int holds_served = 0;
	int hold_left = 0;
	int stall_stretch = 0;
	int cycle_count = 0;
	int mismatch_count = 0;
	int results_checked = 0;
	int strings_ok = 0;
	int input_stall_cycles = 0;
	int settings_run = 0;

	function automatic logic [63:0] width_mask(logic [1:0] vw);
		case (vw)
			VW_8: return 64'h0000_0000_0000_00FF;
			VW_16: return 64'h0000_0000_0000_FFFF;
			VW_32: return 64'h0000_0000_FFFF_FFFF;
			default: return '1;
		endcase
	endfunction

	// Largest magnitude that fits the width, sign and mode
	function automatic logic [63:0] cap_for(cfg_t c, bit neg);
		logic [63:0] m;
		m = width_mask(c.value_width);
		if (!c.signed_mode)
			return m;
		return neg ? (m >> 1) + 64'd1 : m >> 1;
	endfunction

	function automatic bit digit_value(input logic [15:0] u, output logic [63:0] d);
		logic [15:0] letter0;
		letter0 = cfg.upper_case ? CH_UPPER_A : CH_LOWER_A;
		d = '0;
		if (u >= CH_ZERO && u <= CH_NINE) begin
			d = 64'(u - CH_ZERO);
			return 1'b1;
		end
		if (u >= letter0 && u < letter0 + 16'(LETTER_SPAN)) begin
			d = 64'(u - letter0) + 64'd10;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Fold one digit into the magnitude, or mark the string bad
	function automatic void absorb_digit(logic [15:0] u);
		logic [63:0] d, cap, rdx;
		rdx = 64'(cfg.radix);
		if (!digit_value(u, d) || rdx == 0 || d >= rdx) begin
			str_bad = 1'b1;
			return;
		end
		cap = cap_for(cfg, str_neg);
		if (d > cap || str_mag > (cap - d) / rdx) begin
			str_bad = 1'b1;
			return;
		end
		str_mag = str_mag * rdx + d;
		if (str_phase != IN_DIGITS) begin
			str_lead_zero = (u == CH_ZERO);
			str_phase = IN_DIGITS;
		end
	endfunction

	// Advance the shadow by one code unit; return 1 when a result is due
	function automatic bit parse_unit(input logic [15:0] u, input logic fin,
			output logic ok, output logic [63:0] val);
		logic [63:0] m, v;
		ok = 1'b0;
		val = '0;
		if (!str_bad) begin
			case (str_phase)
				AT_START: begin
					if (u == CH_PLUS) begin
						if (cfg.allow_plus)
							str_phase = AFTER_SIGN;
						else
							str_bad = 1'b1;
					end else if (u == CH_MINUS && cfg.signed_mode) begin
						str_neg = 1'b1;
						str_phase = AFTER_SIGN;
					end else begin
						absorb_digit(u);
					end
				end
				AFTER_SIGN: absorb_digit(u);
				default: begin
					if (str_lead_zero && !cfg.allow_leading_zero)
						str_bad = 1'b1;
					else
						absorb_digit(u);
				end
			endcase
		end
		if (!fin)
			return 1'b0;
		if (str_phase != IN_DIGITS)
			str_bad = 1'b1;
		if (!str_bad) begin
			m = width_mask(cfg.value_width);
			v = (str_neg ? 64'd0 - str_mag : str_mag) & m;
			if (cfg.signed_mode && m != '1 && (v & ((m >> 1) + 64'd1)) != 0)
				v = v | ~m;
			ok = 1'b1;
			val = v;
		end
		str_mag = '0;
		str_phase = AT_START;
		str_neg = 1'b0;
		str_bad = 1'b0;
		str_lead_zero = 1'b0;
		return 1'b1;
	endfunction

	function automatic void apply_reg(logic [2:0] idx, logic [5:0] data);
		case (idx)
			REG_RADIX: cfg.radix = data;
			REG_SIGNED_MODE: cfg.signed_mode = data[0];
			REG_VALUE_WIDTH: cfg.value_width = data[1:0];
			REG_ALLOW_PLUS: cfg.allow_plus = data[0];
			REG_ALLOW_LZ: cfg.allow_leading_zero = data[0];
			REG_UPPER_CASE: cfg.upper_case = data[0];
			default: ;
		endcase
	endfunction

	function automatic logic [15:0] digit_char(int d, bit up);
		if (d < 10)
			return CH_ZERO + 16'(d);
		return (up ? CH_UPPER_A : CH_LOWER_A) + 16'(d - 10);
	endfunction

	// Pick a sign, zero, digit, other-case letter, digit or letter edge, or plain noise
	function automatic logic [15:0] odd_unit();
		case ($urandom_range(0, 12))
			0, 1, 2: return 16'($urandom);
			3: return CH_PLUS;
			4: return CH_MINUS;
			5: return CH_ZERO;
			6: return (cfg.upper_case ? CH_LOWER_A : CH_UPPER_A) + 16'($urandom_range(0, 25));
			7: return digit_char($urandom_range(0, 35), cfg.upper_case);
			8: return CH_ZERO - 16'd1;
			9: return CH_NINE + 16'd1;
			10: return CH_UPPER_A + (16'($urandom_range(0, 1)) * 16'(LETTER_SPAN + 1)) - 16'd1;
			default: return CH_LOWER_A + (16'($urandom_range(0, 1)) * 16'(LETTER_SPAN + 1)) - 16'd1;
		endcase
	endfunction

	function automatic void append_magnitude(logic [63:0] mag, int rdx, bit up);
		int pos;
		pos = draft.size();
		do begin
			draft.insert(pos, digit_char(int'(mag % 64'(rdx)), up));
			mag = mag / 64'(rdx);
		end while (mag != 0);
	endfunction

	function automatic void push_text(string t);
		for (int i = 0; i < t.len(); i++)
			text_q.push_back('{16'(t[i]), i == t.len() - 1});
	endfunction

	// Build one string for the current settings and queue its units
	function automatic int add_string();
		logic [63:0] cap, mag;
		int kind, top, maxlen, n;
		bit neg, up, plain_radix;
		draft.delete();
		up = cfg.upper_case;
		plain_radix = cfg.radix >= 2 && cfg.radix <= 36;
		if (cfg.radix > 36)
			top = 36;
		else if (cfg.radix >= 2)
			top = cfg.radix;
		else if (cfg.radix == 1)
			top = 1;
		else
			top = 10;
		maxlen = 3;
		if (cfg.radix >= 2) begin
			cap = cap_for(cfg, 1'b0);
			maxlen = 2;
			while (cap >= 64'(cfg.radix)) begin
				cap = cap / 64'(cfg.radix);
				maxlen++;
			end
		end
		kind = $urandom_range(0, 99);
		if (kind >= 88) begin
			n = $urandom_range(1, 5);
			repeat (n) draft.push_back(odd_unit());
		end else begin
			neg = cfg.signed_mode && ($urandom_range(0, 2) == 0);
			if (neg)
				draft.push_back(CH_MINUS);
			else if ($urandom_range(0, 4) == 0)
				draft.push_back(CH_PLUS);
			if (kind < 22 && plain_radix) begin
				// land on, just under or past the width limit
				cap = cap_for(cfg, neg);
				case ($urandom_range(0, 2))
					0: append_magnitude(cap - 64'($urandom_range(0, cap >= 2 ? 2 : 0)), top, up);
					1: begin
						append_magnitude(cap, top, up);
						draft.push_back(digit_char($urandom_range(0, top - 1), up));
					end
					default: begin
						if (cap != '1) begin
							append_magnitude(cap + 64'd1, top, up);
						end else begin
							append_magnitude(cap, top, up);
							draft.push_back(CH_ZERO);
						end
					end
				endcase
			end else begin
				if ($urandom_range(0, 6) == 0)
					draft.push_back(CH_ZERO);
				n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, maxlen) : $urandom_range(1, 4);
				repeat (n) draft.push_back(digit_char($urandom_range(0, top - 1), up));
			end
			if (kind >= 72)
				draft[$urandom_range(0, draft.size() - 1)] = odd_unit();
		end
		foreach (draft[i])
			text_q.push_back('{draft[i], i == draft.size() - 1});
		return draft.size();
	endfunction

	function automatic void report_mismatch(string field, logic [63:0] exp_v, logic [63:0] got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("Mismatch on %s at result %0d: expected %h, actual %h",
				field, results_checked, exp_v, got);
	endfunction

	// Hold until nothing is queued, in flight or awaited, then let the block settle
	task automatic wait_idle();
		while (text_q.size() != 0 || units_taken != units_offered || pending_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [5:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		apply_reg(idx, data);
	endtask

	// Write every register; registers narrower than the data carry junk in the unused bits
	task automatic set_config(logic [5:0] rdx, bit sm, logic [1:0] vw, bit ap, bit lz, bit uc);
		write_reg(REG_RADIX, rdx);
		write_reg(REG_SIGNED_MODE, {5'($urandom), sm});
		write_reg(REG_VALUE_WIDTH, {4'($urandom), vw});
		write_reg(REG_ALLOW_PLUS, {5'($urandom), ap});
		write_reg(REG_ALLOW_LZ, {5'($urandom), lz});
		write_reg(REG_UPPER_CASE, {5'($urandom), uc});
		if ($urandom_range(0, 2) == 0)
			write_reg(NO_REG_FIRST + 3'($urandom_range(0, 1)), 6'($urandom));
		@(negedge clk);
		cfg_valid <= 1'b0;
		settings_run++;
	endtask

	task automatic run_phase(logic [5:0] rdx, bit sm, logic [1:0] vw, bit ap, bit lz, bit uc,
			int smode, int rmode, bit long_hold);
		int queued;
		wait_idle();
		set_config(rdx, sm, vw, ap, lz, uc);
		send_mode = smode;
		stall_mode = rmode;
		if (long_hold)
			hold_requests++;
		queued = 0;
		while (queued < PHASE_UNITS)
			queued += add_string();
	endtask

	initial begin
		forever #2 clk = ~clk;
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("Verification failed");
			$finish;
		end
	end

	// Offer code units, in bursts when send_mode is set; hold each beat until it is taken
	always @(negedge clk) begin
		if (arst_n && !(in_valid && units_taken != units_offered)) begin
			if (gap_left > 0) begin
				in_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (text_q.size() != 0) begin
				beat = text_q.pop_front();
				in_valid <= 1'b1;
				code_unit <= beat.code;
				last_unit <= beat.fin;
				// count the beat at once so an idle check never sees it popped but uncounted
				units_offered = units_offered + 1;
				if (send_mode != 0 && burst_left <= 1) begin
					burst_left <= (send_mode == 1) ? $urandom_range(1, 16) : $urandom_range(1, 4);
					gap_left <= (send_mode == 1) ? $urandom_range(0, 3) : $urandom_range(1, 10);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Stall the result side in stretches, or for one long hold on request
	always @(negedge clk) begin
		if (hold_requests != holds_served) begin
			holds_served <= holds_served + 1;
			hold_left <= LONG_HOLD;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else if (stall_mode == 0) begin
			out_stall <= 1'b0;
		end else if (stall_stretch > 0) begin
			stall_stretch <= stall_stretch - 1;
		end else begin
			out_stall <= ~out_stall;
			if (out_stall)
				stall_stretch <= $urandom_range(0, 6);
			else
				stall_stretch <= (stall_mode == 1) ? $urandom_range(0, 2) : $urandom_range(1, 8);
		end
	end

	// Predict on every taken unit; check every taken result against the oldest prediction
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_stall)
				input_stall_cycles++;
			if (in_valid && !in_stall) begin
				units_taken <= units_taken + 1;
				if (parse_unit(code_unit, last_unit, exp_ok, exp_val))
					pending_results.push_back('{exp_ok, exp_val});
			end
			if (out_valid && !out_stall) begin
				results_checked++;
				if (pending_results.size() == 0) begin
					report_mismatch("unrequested beat", '0, value);
				end else begin
					want = pending_results.pop_front();
					if (want.ok)
						strings_ok++;
					if (accepted !== want.ok)
						report_mismatch("accepted", 64'(want.ok), 64'(accepted));
					if (value !== want.val)
						report_mismatch("value", want.val, value);
				end
			end
		end
	end

	initial begin
		int r;
		logic [5:0] rdx;
		cfg = '{radix: RADIX_RESET, signed_mode: 1'b0, value_width: VW_64,
			allow_plus: 1'b0, allow_leading_zero: 1'b0, upper_case: 1'b0};
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Defaults after reset: plain, plus and minus refused, leading zero, bad units
		push_text("0");
		push_text("42");
		push_text("+7");
		push_text("-1");
		push_text("05");
		push_text("x");
		text_q.push_back('{16'hFFFF, 1'b0});
		push_text("1");
		text_q.push_back('{16'h0000, 1'b1});

		// Signed byte: both limits, lone signs, negative zero, overflow
		wait_idle();
		set_config(6'd10, 1'b1, VW_8, 1'b1, 1'b0, 1'b0);
		push_text("-128");
		push_text("127");
		push_text("+");
		push_text("-");
		push_text("-0");
		push_text("128");

		run_phase(6'd16, 1'b0, VW_64, 1'b1, 1'b1, 1'b1, 0, 0, 1'b0);
		run_phase(6'd2, 1'b1, VW_8, 1'b1, 1'b0, 1'b0, 1, 1, 1'b0);
		run_phase(6'd36, 1'b1, VW_64, 1'b0, 1'b1, 1'b0, 2, 2, 1'b0);
		run_phase(6'd36, 1'b0, VW_16, 1'b1, 1'b0, 1'b1, 1, 2, 1'b0);
		run_phase(6'd10, 1'b1, VW_32, 1'b1, 1'b1, 1'b0, 0, 0, 1'b1);
		run_phase(6'd8, 1'b0, VW_8, 1'b0, 1'b0, 1'b0, 2, 1, 1'b0);
		run_phase(6'd1, 1'b0, VW_32, 1'b0, 1'b1, 1'b0, 1, 0, 1'b0);
		run_phase(6'd0, 1'b1, VW_16, 1'b1, 1'b0, 1'b1, 0, 1, 1'b0);
		run_phase(6'd63, 1'b1, VW_64, 1'b1, 1'b1, 1'b1, 2, 2, 1'b0);
		run_phase(6'd37, 1'b0, VW_8, 1'b0, 1'b1, 1'b0, 1, 1, 1'b0);
		repeat (4) begin
			r = $urandom_range(0, 9);
			if (r < 8)
				rdx = 6'($urandom_range(2, 36));
			else if (r == 8)
				rdx = 6'($urandom_range(0, 1));
			else
				rdx = 6'($urandom_range(37, 63));
			run_phase(rdx, 1'($urandom), 2'($urandom), 1'($urandom), 1'($urandom),
				1'($urandom), $urandom_range(0, 2), $urandom_range(0, 2), 1'b0);
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		mismatch_count += pending_results.size();
		$display("Checked %0d strings (%0d accepted) built from %0d code units under %0d settings",
			results_checked, strings_ok, units_taken, settings_run);
		$display("Input held off for %0d cycles, including a long output hold", input_stall_cycles);
		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/rip_pkg.sv
hdl/rip_cfg.sv
hdl/rip_dp.sv
hdl/rip_ctrl.sv
hdl/radix_integer_parser.sv
bench/tb.sv
